/* sv/bsfr_pkg.sv */
package bsfr_pkg;

    // Framing bytes
    localparam logic [7:0] FLAG_BYTE    = 8'h7E;
    localparam logic [7:0] ESC_BYTE     = 8'h7D;
    localparam logic [7:0] ESC_FOR_ESC  = 8'h01;
    localparam logic [7:0] ESC_FOR_FLAG = 8'h02;

    // Raw length counter
    localparam int          LEN_W         = 11;
    localparam int          LEN_FIELD_MAX = 2047;
    localparam int          MAX_FRAME_LEN_DEF = 1024;

    // Configuration reset value
    localparam logic [7:0] MIN_FRAME_LEN_RST = 8'd15;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_GOOD    = 3'd1,
        KIND_BAD_XOR = 3'd2,
        KIND_BAD_ESC = 3'd3,
        KIND_SHORT   = 3'd4
    } kind_t;

    // One decoded result, valid only when has_result is set
    typedef struct packed {
        logic       has_result;
        kind_t      kind;
        logic [7:0] data;
    } result_t;

endpackage

/* sv/bsfr_in_stage.sv */
module bsfr_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Accept a new item when empty or when the held item moves on this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

/* sv/bsfr_decode.sv */
module bsfr_decode #(
    parameter int MAX_FRAME_LEN = bsfr_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         cur_byte,
    input  logic [7:0]         min_frame_len,
    output bsfr_pkg::result_t  res
);

    localparam int LEN_CAP_INT = (MAX_FRAME_LEN < bsfr_pkg::LEN_FIELD_MAX) ?
                                 MAX_FRAME_LEN : bsfr_pkg::LEN_FIELD_MAX;
    localparam logic [bsfr_pkg::LEN_W-1:0] LEN_CAP = bsfr_pkg::LEN_W'(LEN_CAP_INT);
    localparam logic [bsfr_pkg::LEN_W-1:0] LEN_ONE = bsfr_pkg::LEN_W'(1);

    logic                      in_frame_reg,   in_frame_next;
    logic                      esc_pend_reg,   esc_pend_next;
    logic                      esc_err_reg,    esc_err_next;
    logic [7:0]                xor_reg,        xor_next;
    logic [bsfr_pkg::LEN_W-1:0] len_reg,       len_next;
    logic [bsfr_pkg::LEN_W-1:0] len_inc;
    logic                      is_flag;

    // Saturating length count
    assign len_inc = (len_reg < LEN_CAP) ? (len_reg + LEN_ONE) : len_reg;
    assign is_flag = (cur_byte == bsfr_pkg::FLAG_BYTE);

    // Per-byte decode and state update
    always_comb
    begin
        in_frame_next  = in_frame_reg;
        esc_pend_next  = esc_pend_reg;
        esc_err_next   = esc_err_reg;
        xor_next       = xor_reg;
        len_next       = len_reg;
        res.has_result = 1'b0;
        res.kind       = bsfr_pkg::KIND_DATA;
        res.data       = 8'h00;

        if (!in_frame_reg)
        begin
            // hunting: only a delimiter matters
            if (is_flag)
            begin
                in_frame_next = 1'b1;
                esc_pend_next = 1'b0;
                esc_err_next  = 1'b0;
                xor_next      = 8'h00;
                len_next      = LEN_ONE;
            end
        end
        else if (is_flag)
        begin
            // closing delimiter
            res.has_result = 1'b1;
            if (len_inc < {3'b000, min_frame_len})
            begin
                res.kind      = bsfr_pkg::KIND_SHORT;
                in_frame_next = 1'b1;
                len_next      = LEN_ONE;
            end
            else
            begin
                if (esc_err_reg || esc_pend_reg)
                begin
                    res.kind = bsfr_pkg::KIND_BAD_ESC;
                end
                else if (xor_reg != 8'h00)
                begin
                    res.kind = bsfr_pkg::KIND_BAD_XOR;
                end
                else
                begin
                    res.kind = bsfr_pkg::KIND_GOOD;
                end
                in_frame_next = 1'b0;
                len_next      = '0;
            end
            esc_pend_next = 1'b0;
            esc_err_next  = 1'b0;
            xor_next      = 8'h00;
        end
        else
        begin
            len_next = len_inc;
            if (esc_pend_reg)
            begin
                // second byte of an escape pair
                esc_pend_next = 1'b0;
                if (cur_byte == bsfr_pkg::ESC_FOR_ESC)
                begin
                    res.has_result = 1'b1;
                    res.data       = bsfr_pkg::ESC_BYTE;
                    xor_next       = xor_reg ^ bsfr_pkg::ESC_BYTE;
                end
                else if (cur_byte == bsfr_pkg::ESC_FOR_FLAG)
                begin
                    res.has_result = 1'b1;
                    res.data       = bsfr_pkg::FLAG_BYTE;
                    xor_next       = xor_reg ^ bsfr_pkg::FLAG_BYTE;
                end
                else
                begin
                    esc_err_next = 1'b1;
                end
            end
            else if (cur_byte == bsfr_pkg::ESC_BYTE)
            begin
                esc_pend_next = 1'b1;
            end
            else
            begin
                res.has_result = 1'b1;
                res.data       = cur_byte;
                xor_next       = xor_reg ^ cur_byte;
            end
        end
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_pend_reg <= 1'b0;
            esc_err_reg  <= 1'b0;
            xor_reg      <= 8'h00;
            len_reg      <= '0;
        end
        else if (step)
        begin
            in_frame_reg <= in_frame_next;
            esc_pend_reg <= esc_pend_next;
            esc_err_reg  <= esc_err_next;
            xor_reg      <= xor_next;
            len_reg      <= len_next;
        end
    end

endmodule

/* sv/byte_stuffing_frame_receiver_core.sv */
// out_valid rises when the result of the held input item is registered.
// Throughput: one item per cycle while the output is not stalled; the
// per-byte decode sits between the input register and the output register.
// Bytes giving no result (hunting, escape marks) pass a stalled output.
// Reset (rst_n, async, active low) returns to hunting, empties both
// registers and sets min_frame_len to 15.
module byte_stuffing_frame_receiver_core #(
    parameter int MAX_FRAME_LEN = bsfr_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] out_kind,
    output logic [7:0] out_byte
);

    logic              held_valid;
    logic [7:0]        held_byte;
    logic              step;
    bsfr_pkg::result_t res;

    logic [7:0] min_len_reg;
    logic       out_valid_reg, out_valid_next;
    logic [2:0] out_kind_reg;
    logic [7:0] out_byte_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= bsfr_pkg::MIN_FRAME_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            min_len_reg <= cfg_wr_data;
        end
    end

    bsfr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .take       (step),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    bsfr_decode #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .cur_byte      (held_byte),
        .min_frame_len (min_len_reg),
        .res           (res)
    );

    // Held item moves on when its result has room, or it gives none
    assign step = held_valid && (!res.has_result || !out_valid_reg || out_ready);

    always_comb
    begin
        if (step && res.has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res.has_result)
        begin
            out_kind_reg <= res.kind;
            out_byte_reg <= res.data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;

endmodule
